// ===== sv/mmsp_pkg.sv =====
package mmsp_pkg;

  // Width of the signed motion totals.
  localparam int ACC_WIDTH = 16;

  // Packets that can wait between the classifier and the serializer.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  // Item kinds.
  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Register reset value.
  localparam logic [7:0] SEND_INTERVAL_RESET = 8'd25;

  // Byte position within a packet.
  localparam logic [1:0] BYTE_FIRST = 2'd0;
  localparam logic [1:0] BYTE_MID   = 2'd1;
  localparam logic [1:0] BYTE_LAST  = 2'd2;

  typedef logic signed [ACC_WIDTH-1:0] acc_t;

  typedef struct packed {
    logic              op;
    logic [6:0]        report_length;
    logic [7:0]        report_buttons;
    logic signed [7:0] report_dx;
    logic signed [7:0] report_dy;
    logic              host_powered;
    logic [4:0]        fifo_room;
  } in_item_t;

  typedef struct packed {
    logic [7:0] serial_byte;
    logic       last_of_packet;
  } out_item_t;

  // One complete three-byte mouse packet.
  typedef struct packed {
    logic [7:0] byte2;
    logic [7:0] byte1;
    logic [7:0] byte0;
  } packet_t;

  // Queue occupancy seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== sv/mouse_motion_to_serial_packet_top.sv =====
// Serial mouse packet encoder. Each input transaction is either a boot mouse
// report or a one-millisecond tick; reports add motion into saturating totals,
// and a tick that finds a backlog, an expired countdown, host power and room
// for three bytes in the receive FIFO emits one three-byte serial mouse packet.
// An input transaction is taken whenever the two-entry packet queue has a free
// slot, so reports and ticks can arrive every cycle. A packet leaves as three
// output transactions, one byte per cycle while out_ready is high; a tick's
// packet is written into the queue and, once the serializer is free, loaded
// into its packet register before its first byte is offered. The byte serializer
// bounds the sustained packet rate. send_interval is written through the cfg port, which is always ready.
module mouse_motion_to_serial_packet_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mmsp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mmsp_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import mmsp_pkg::*;

  logic      push, pop;
  packet_t   push_pkt, head_pkt;
  q_status_t q_status;

  assign cfg_ready = 1'b1;

  // Front end: classify transactions and build packets.
  mmsp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .q_status (q_status),
    .push     (push),
    .push_pkt (push_pkt)
  );

  // Packet queue between the two sides.
  mmsp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_pkt(push_pkt),
    .pop     (pop),
    .head_pkt(head_pkt),
    .status  (q_status)
  );

  // Back end: serialize packets into bytes.
  mmsp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .head_pkt (head_pkt),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== sv/mmsp_front.sv =====
module mmsp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mmsp_pkg::in_item_t in_data,
  input  logic              cfg_valid,
  input  logic [7:0]        cfg_data,
  input  mmsp_pkg::q_status_t q_status,
  output logic              push,
  output mmsp_pkg::packet_t push_pkt
);
  import mmsp_pkg::*;

  localparam acc_t ACC_MAX   = acc_t'({1'b0, {(ACC_WIDTH-1){1'b1}}});
  localparam acc_t ACC_MIN   = acc_t'({1'b1, {(ACC_WIDTH-1){1'b0}}});
  localparam acc_t CLAMP_HI  = acc_t'(63);
  localparam acc_t CLAMP_LO  = acc_t'(-64);
  localparam logic [6:0] MIN_REPORT_LEN = 7'd3;
  localparam logic [4:0] MIN_FIFO_ROOM  = 5'd3;
  localparam logic [7:0] SYNC_BIT       = 8'h40;

  // Saturating add of a signed byte to a total.
  function automatic acc_t sat_add(input acc_t a, input logic signed [7:0] d);
    logic signed [ACC_WIDTH:0] s;
    s = {a[ACC_WIDTH-1], a} + (ACC_WIDTH+1)'(d);
    if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
      return s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_WIDTH-1:0];
  endfunction

  // Clamp a total to the seven-bit packet range.
  function automatic logic signed [6:0] clamp7(input acc_t v);
    if (v > CLAMP_HI) begin
      return 7'sd63;
    end
    if (v < CLAMP_LO) begin
      return -7'sd64;
    end
    return v[6:0];
  endfunction

  acc_t        pending_x, pending_x_next;
  acc_t        pending_y, pending_y_next;
  logic [1:0]  pending_keys, pending_keys_next;
  logic        backlog, backlog_next;
  logic [7:0]  countdown, countdown_next;
  logic [7:0]  send_interval;

  logic              accept;
  logic [7:0]        cd_dec;
  logic signed [6:0] sx, sy;
  logic [7:0]        ux, uy;
  logic              send;

  // Any item may enter while the packet queue has a free slot.
  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  // Packet contents come straight from the current totals.
  assign cd_dec = (countdown != 8'd0) ? countdown - 8'd1 : 8'd0;
  assign sx     = clamp7(pending_x);
  assign sy     = clamp7(pending_y);
  assign ux     = {sx[6], sx};
  assign uy     = {sy[6], sy};
  assign send   = accept && (in_data.op == OP_TICK) && in_data.host_powered && backlog &&
                  (cd_dec == 8'd0) && (in_data.fifo_room >= MIN_FIFO_ROOM);

  assign push           = send;
  assign push_pkt.byte0 = SYNC_BIT | {2'b00, pending_keys[0], pending_keys[1],
                                      uy[7:6], ux[7:6]};
  assign push_pkt.byte1 = {2'b00, ux[5:0]};
  assign push_pkt.byte2 = {2'b00, uy[5:0]};

  // Next values of the motion state for each kind of transaction.
  always_comb begin
    pending_x_next    = pending_x;
    pending_y_next    = pending_y;
    pending_keys_next = pending_keys;
    backlog_next      = backlog;
    countdown_next    = countdown;
    if (accept) begin
      if (in_data.op == OP_REPORT) begin
        if (in_data.report_length >= MIN_REPORT_LEN) begin
          if (!in_data.host_powered) begin
            pending_x_next = '0;
            pending_y_next = '0;
            backlog_next   = 1'b0;
          end else begin
            pending_x_next    = sat_add(pending_x, in_data.report_dx);
            pending_y_next    = sat_add(pending_y, in_data.report_dy);
            pending_keys_next = in_data.report_buttons[1:0];
            backlog_next      = 1'b1;
          end
        end
      end else begin
        countdown_next = cd_dec;
        if (!in_data.host_powered) begin
          pending_x_next = '0;
          pending_y_next = '0;
          backlog_next   = 1'b0;
        end else if (send) begin
          pending_x_next = pending_x - ACC_WIDTH'(sx);
          pending_y_next = pending_y - ACC_WIDTH'(sy);
          backlog_next   = (pending_x_next != '0) || (pending_y_next != '0);
          countdown_next = send_interval;
        end
      end
    end
  end

  // State registers and the interval register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_x     <= '0;
      pending_y     <= '0;
      pending_keys  <= '0;
      backlog       <= 1'b0;
      countdown     <= '0;
      send_interval <= SEND_INTERVAL_RESET;
    end else begin
      pending_x    <= pending_x_next;
      pending_y    <= pending_y_next;
      pending_keys <= pending_keys_next;
      backlog      <= backlog_next;
      countdown    <= countdown_next;
      if (cfg_valid) begin
        send_interval <= cfg_data;
      end
    end
  end

  // A tick without host power always drops the backlog.
  a_poweroff_clears: assert property (@(posedge clk) disable iff (rst)
    accept && (in_data.op == OP_TICK) && !in_data.host_powered |=> !backlog && pending_x == '0)
    else $error("backlog survived a power-off tick");

  // A packet is only built from an existing backlog.
  a_send_needs_backlog: assert property (@(posedge clk) disable iff (rst)
    push |-> backlog && !q_status.full)
    else $error("packet pushed without backlog or queue room");

endmodule

// ===== sv/mmsp_queue.sv =====
module mmsp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mmsp_pkg::packet_t   push_pkt,
  input  logic                pop,
  output mmsp_pkg::packet_t   head_pkt,
  output mmsp_pkg::q_status_t status
);
  import mmsp_pkg::*;

  packet_t                 slots [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_WIDTH-1:0]   count;

  assign status.full  = (count == QCNT_WIDTH'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head_pkt     = slots[rd_ptr];

  // Advance a pointer with wrap at the queue depth.
  function automatic logic [QPTR_WIDTH-1:0] bump(input logic [QPTR_WIDTH-1:0] p);
    return (p == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Packet storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_pkt;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Occupancy stays within the depth and pops only take stored packets.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_WIDTH'(QUEUE_DEPTH))
    else $error("queue occupancy out of range");

  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("pop from empty queue");

endmodule

// ===== sv/mmsp_back.sv =====
module mmsp_back (
  input  logic                clk,
  input  logic                rst,
  input  mmsp_pkg::q_status_t q_status,
  input  mmsp_pkg::packet_t   head_pkt,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output mmsp_pkg::out_item_t out_data
);
  import mmsp_pkg::*;

  packet_t    cur_pkt;
  logic [1:0] byte_idx;
  logic       busy;
  logic       last_taken;

  assign out_valid  = busy;
  assign last_taken = busy && out_ready && (byte_idx == BYTE_LAST);
  assign pop        = !q_status.empty && (!busy || last_taken);

  // Select the byte that is on offer.
  always_comb begin
    out_data.last_of_packet = (byte_idx == BYTE_LAST);
    case (byte_idx)
      BYTE_FIRST: out_data.serial_byte = cur_pkt.byte0;
      BYTE_MID:   out_data.serial_byte = cur_pkt.byte1;
      default:    out_data.serial_byte = cur_pkt.byte2;
    endcase
  end

  // Load a packet, then step through its bytes as each transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      byte_idx <= BYTE_FIRST;
    end else if (pop) begin
      busy     <= 1'b1;
      byte_idx <= BYTE_FIRST;
    end else if (busy && out_ready) begin
      if (byte_idx == BYTE_LAST) begin
        busy <= 1'b0;
      end else begin
        byte_idx <= byte_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_pkt <= head_pkt;
    end
  end

  // The byte position never passes the last byte of a packet.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> byte_idx != 2'd3)
    else $error("byte index out of range");

endmodule
